// ===== rtl/angle_bias_kalman_filter_unit_assert.svh =====
// Assertion macros for the angle/bias Kalman filter unit.
// Each macro expects clk and arst_n in scope.
`ifndef ANGLE_BIAS_KALMAN_FILTER_UNIT_ASSERT_SVH
`define ANGLE_BIAS_KALMAN_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ABKF_ASSERT_IMP(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("abkf assertion failed");

// Next-cycle implication.
`define ABKF_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("abkf assertion failed");

`endif

// ===== rtl/abkf_pkg.sv =====
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types, constants and saturating helpers of the Kalman filter unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package abkf_pkg;
	localparam int WORD_W = 32;
	localparam int FRAC_W = 20;
	localparam int QUO_W  = WORD_W + FRAC_W;
	localparam int DT_W   = 21;
	localparam int NOISE_W = 31;
	localparam int STEP_W = 4;

	localparam logic [NOISE_W-1:0] QA_RESET = 31'd10486;
	localparam logic [NOISE_W-1:0] QB_RESET = 31'd315;
	localparam logic [NOISE_W-1:0] R_RESET  = 31'd943718;

	localparam logic [1:0] REG_QA = 2'd0;
	localparam logic [1:0] REG_QB = 2'd1;
	localparam logic [1:0] REG_R  = 2'd2;

	// micro-steps of the sequencer (each is one multiply and a write-back)
	localparam logic [STEP_W-1:0] STP_PRED_ANG = 4'd0;
	localparam logic [STEP_W-1:0] STP_P00_A    = 4'd1;
	localparam logic [STEP_W-1:0] STP_P00_B    = 4'd2;
	localparam logic [STEP_W-1:0] STP_P01      = 4'd3;
	localparam logic [STEP_W-1:0] STP_P11      = 4'd4;
	localparam logic [STEP_W-1:0] STP_COR_ANG  = 4'd5;
	localparam logic [STEP_W-1:0] STP_COR_BIAS = 4'd6;
	localparam logic [STEP_W-1:0] STP_C00      = 4'd7;
	localparam logic [STEP_W-1:0] STP_C01      = 4'd8;
	localparam logic [STEP_W-1:0] STP_C10      = 4'd9;
	localparam logic [STEP_W-1:0] STP_C11      = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_WB,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef logic signed [WORD_W-1:0] word_t;

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		return s[WORD_W-1:0];
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1])
			return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
		return s[WORD_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/abkf_mul.sv =====
// ----------------------------------------------------------------------------
// abkf_mul
// Shared fixed-point multiplier: product registered, then rounded and
// saturated to the word on the following cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module abkf_mul (
	input  wire logic           clk,
	input  wire abkf_pkg::word_t a,
	input  wire abkf_pkg::word_t b,
	output abkf_pkg::word_t      res
);
	localparam int PW = 2 * abkf_pkg::WORD_W;
	localparam int SW = PW + 1 - abkf_pkg::FRAC_W;

	logic [abkf_pkg::WORD_W-1:0] ma, mb;
	logic [PW-1:0] prod_s1;
	logic          neg_s1;
	logic [PW:0]   rnd;
	logic [SW-1:0] sh, lim, mg;

	assign ma = a[abkf_pkg::WORD_W-1] ? -a : a;
	assign mb = b[abkf_pkg::WORD_W-1] ? -b : b;

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		neg_s1  <= a[abkf_pkg::WORD_W-1] ^ b[abkf_pkg::WORD_W-1];
	end

	always_comb begin
		rnd = {1'b0, prod_s1} + ((PW+1)'(1) << (abkf_pkg::FRAC_W - 1));
		sh  = rnd[PW:abkf_pkg::FRAC_W];
		lim = neg_s1 ? (SW'(1) << (abkf_pkg::WORD_W - 1))
			: ((SW'(1) << (abkf_pkg::WORD_W - 1)) - SW'(1));
		mg  = (sh > lim) ? lim : sh;
		res = neg_s1 ? -mg[abkf_pkg::WORD_W-1:0] : mg[abkf_pkg::WORD_W-1:0];
	end
endmodule
`default_nettype wire

// ===== rtl/abkf_div.sv =====
// ----------------------------------------------------------------------------
// abkf_div
// Iterative restoring divider, one quotient bit per cycle, computing
// (a << FRAC) / b rounded to nearest and saturated to the word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module abkf_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire abkf_pkg::word_t a,
	input  wire abkf_pkg::word_t b,
	output logic                 done,
	output abkf_pkg::word_t      q
);
	localparam int W  = abkf_pkg::WORD_W;
	localparam int QW = abkf_pkg::QUO_W;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] num_q, quo_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  md_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    rem_sh;
	logic          ge;
	logic [W-1:0]  ma;
	logic [QW:0]   qr, lim, mg;

	assign ma     = a[W-1] ? -a : a;
	assign rem_sh = {rem_q[W-1:0], num_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, md_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {ma, {abkf_pkg::FRAC_W{1'b0}}};
			md_q  <= b[W-1] ? -b : b;
			neg_q <= a[W-1] ^ b[W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[QW-2:0], 1'b0};
			rem_q <= ge ? rem_sh - {1'b0, md_q} : rem_sh;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_comb begin
		// round up when twice the remainder reaches the divisor
		qr  = {1'b0, quo_q} + (QW+1)'({rem_q, 1'b0} >= {1'b0, md_q, 1'b0} >> 1
			? ({rem_q, 1'b0} >= {2'b0, md_q}) : 1'b0);
		lim = neg_q ? ((QW+1)'(1) << (W - 1)) : (((QW+1)'(1) << (W - 1)) - (QW+1)'(1));
		mg  = (qr > lim) ? lim : qr;
		q   = neg_q ? -mg[W-1:0] : mg[W-1:0];
	end

	assign done = done_q;
endmodule
`default_nettype wire

// ===== rtl/angle_bias_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Angle/bias Kalman filter unit.
// Input channel: measured_angle, measured_rate, time_step with in_valid and
// in_stall; a request is taken when in_valid is high and in_stall is low.
// Output channel: angle_estimate, bias_estimate with out_valid and out_stall.
// Noise registers sit on an APB-style port at byte addresses 0, 4 and 8.
// One request runs through eleven multiply steps, each a multiply state and a
// write-back state, on one shared multiplier and two divisions on one
// iterative divider, each made of a start, one iteration for each of the 52
// quotient bits and a hand-off. The result is loaded into the output register
// once the last step is done, and the next request can be taken in the cycle
// after the load. A zero innovation variance skips both divisions.
// in_stall stays high while a request is being worked on.
// Reset clears the angle, bias and covariance to zero and loads the default
// noise values. While the receiver holds out_stall, the result stays in the
// output register; a finished next result waits until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module angle_bias_kalman_filter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] measured_angle,
	input  wire logic [31:0] measured_rate,
	input  wire logic [20:0] time_step,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      angle_estimate,
	output logic [31:0]      bias_estimate,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	`include "angle_bias_kalman_filter_unit_assert.svh"

	localparam int W = abkf_pkg::WORD_W;

	abkf_pkg::state_t state_q, state_d;
	logic [abkf_pkg::STEP_W-1:0] step_q;
	logic [abkf_pkg::NOISE_W-1:0] qa_q, qb_q, r_q;
	abkf_pkg::word_t ang_q, bias_q, p0_q, p1_q, p2_q, p3_q;
	abkf_pkg::word_t meas_q, t_q, s_q, y_q, k0_q, k1_q;
	logic [abkf_pkg::DT_W-1:0] dt_q;
	logic div_sel_q;
	logic out_valid_q;
	logic [31:0] ang_out_q, bias_out_q;

	abkf_pkg::word_t dtw, ma_op, mb_op, m_res, div_a, div_q;
	logic div_start, div_done, in_acc, out_load, cfg_wr;

	assign dtw    = {{(W - abkf_pkg::DT_W){1'b0}}, dt_q};
	assign in_acc = in_valid && !in_stall;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	abkf_mul u_mul (.clk(clk), .a(ma_op), .b(mb_op), .res(m_res));

	assign div_a = div_sel_q ? p2_q : p0_q;
	abkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.a(div_a), .b(s_q), .done(div_done), .q(div_q)
	);

	// operand select per step
	always_comb begin
		ma_op = dtw;
		mb_op = t_q;
		case (step_q)
			abkf_pkg::STP_PRED_ANG: begin ma_op = dtw; mb_op = t_q; end
			abkf_pkg::STP_P00_A:    begin ma_op = dtw; mb_op = t_q; end
			abkf_pkg::STP_P00_B:    begin ma_op = {1'b0, qa_q}; mb_op = dtw; end
			abkf_pkg::STP_P01:      begin ma_op = dtw; mb_op = p3_q; end
			abkf_pkg::STP_P11:      begin ma_op = {1'b0, qb_q}; mb_op = dtw; end
			abkf_pkg::STP_COR_ANG:  begin ma_op = k0_q; mb_op = y_q; end
			abkf_pkg::STP_COR_BIAS: begin ma_op = k1_q; mb_op = y_q; end
			abkf_pkg::STP_C00:      begin ma_op = k0_q; mb_op = p0_q; end
			abkf_pkg::STP_C01:      begin ma_op = k0_q; mb_op = p1_q; end
			abkf_pkg::STP_C10:      begin ma_op = k1_q; mb_op = p0_q; end
			abkf_pkg::STP_C11:      begin ma_op = k1_q; mb_op = p1_q; end
			default:                begin ma_op = dtw; mb_op = t_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= abkf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			abkf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_d = abkf_pkg::ST_MUL;
			end
			abkf_pkg::ST_MUL:
				state_d = abkf_pkg::ST_WB;
			abkf_pkg::ST_WB: begin
				if (step_q == abkf_pkg::STP_P11)
					state_d = abkf_pkg::ST_DIV_GO;
				else if (step_q == abkf_pkg::STP_C11)
					state_d = abkf_pkg::ST_DONE;
				else
					state_d = abkf_pkg::ST_MUL;
			end
			abkf_pkg::ST_DIV_GO: begin
				if (s_q == '0) begin
					state_d = abkf_pkg::ST_MUL;
				end else begin
					div_start = 1'b1;
					state_d   = abkf_pkg::ST_DIV_WAIT;
				end
			end
			abkf_pkg::ST_DIV_WAIT: begin
				if (div_done)
					state_d = div_sel_q ? abkf_pkg::ST_MUL : abkf_pkg::ST_DIV_GO;
			end
			abkf_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = abkf_pkg::ST_IDLE;
				end
			end
			default:
				state_d = abkf_pkg::ST_IDLE;
		endcase
	end

	// filter state and sequencer bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q     <= '0;
			bias_q    <= '0;
			p0_q      <= '0;
			p1_q      <= '0;
			p2_q      <= '0;
			p3_q      <= '0;
			step_q    <= '0;
			div_sel_q <= 1'b0;
		end else begin
			if (in_acc) begin
				step_q    <= abkf_pkg::STP_PRED_ANG;
				div_sel_q <= 1'b0;
			end
			if (state_q == abkf_pkg::ST_WB) begin
				step_q <= step_q + abkf_pkg::STEP_W'(1);
				case (step_q)
					abkf_pkg::STP_PRED_ANG: ang_q <= abkf_pkg::sat_add(ang_q, m_res);
					abkf_pkg::STP_P00_B:
						p0_q <= abkf_pkg::sat_add(p0_q, abkf_pkg::sat_add(t_q, m_res));
					abkf_pkg::STP_P01: begin
						p1_q <= abkf_pkg::sat_sub(p1_q, m_res);
						p2_q <= abkf_pkg::sat_sub(p2_q, m_res);
					end
					abkf_pkg::STP_P11:      p3_q   <= abkf_pkg::sat_add(p3_q, m_res);
					abkf_pkg::STP_COR_ANG:  ang_q  <= abkf_pkg::sat_add(ang_q, m_res);
					abkf_pkg::STP_COR_BIAS: bias_q <= abkf_pkg::sat_add(bias_q, m_res);
					abkf_pkg::STP_C00:      p0_q   <= abkf_pkg::sat_sub(p0_q, m_res);
					abkf_pkg::STP_C01:      p1_q   <= abkf_pkg::sat_sub(p1_q, m_res);
					abkf_pkg::STP_C10:      p2_q   <= abkf_pkg::sat_sub(p2_q, m_res);
					abkf_pkg::STP_C11:      p3_q   <= abkf_pkg::sat_sub(p3_q, m_res);
					default: ;
				endcase
			end
			if (state_q == abkf_pkg::ST_DIV_WAIT && div_done)
				div_sel_q <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_q <= measured_angle;
			dt_q   <= time_step;
			t_q    <= abkf_pkg::sat_sub(measured_rate, bias_q);
		end
		if (state_q == abkf_pkg::ST_WB) begin
			case (step_q)
				abkf_pkg::STP_PRED_ANG: begin
					t_q <= abkf_pkg::sat_add(p3_q, p1_q);
					y_q <= abkf_pkg::sat_sub(meas_q, abkf_pkg::sat_add(ang_q, m_res));
				end
				abkf_pkg::STP_P00_A: t_q <= m_res;
				abkf_pkg::STP_P11:   s_q <= abkf_pkg::sat_add(p0_q, {1'b0, r_q});
				default: ;
			endcase
		end
		if (state_q == abkf_pkg::ST_DIV_GO && s_q == '0) begin
			k0_q <= '0;
			k1_q <= '0;
		end
		if (state_q == abkf_pkg::ST_DIV_WAIT && div_done) begin
			if (div_sel_q)
				k1_q <= div_q;
			else
				k0_q <= div_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ang_out_q  <= ang_q;
			bias_out_q <= bias_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign angle_estimate = ang_out_q;
	assign bias_estimate  = bias_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= abkf_pkg::QA_RESET;
			qb_q <= abkf_pkg::QB_RESET;
			r_q  <= abkf_pkg::R_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				abkf_pkg::REG_QA: qa_q <= pwdata[30:0];
				abkf_pkg::REG_QB: qb_q <= pwdata[30:0];
				abkf_pkg::REG_R:  r_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			abkf_pkg::REG_QA: prdata = {1'b0, qa_q};
			abkf_pkg::REG_QB: prdata = {1'b0, qb_q};
			abkf_pkg::REG_R:  prdata = {1'b0, r_q};
			default:          prdata = '0;
		endcase
	end

	`ABKF_ASSERT_NXT(a_accept_starts, in_acc, state_q == abkf_pkg::ST_MUL)
	`ABKF_ASSERT_IMP(a_div_nonzero, div_start, s_q != '0)
	`ABKF_ASSERT_IMP(a_done_in_wait, div_done, state_q == abkf_pkg::ST_DIV_WAIT)
	`ABKF_ASSERT_IMP(a_load_free, out_load, !out_valid_q || !out_stall)
endmodule
`default_nettype wire
